// ----- rtl/core/ntt_pkg.sv -----
package ntt_pkg;

    localparam int NTT_PTS  = 1024;
    localparam int NTT_AW   = $clog2(NTT_PTS);
    localparam int NTT_DW   = 31;
    localparam int NTT_KW   = 4;
    localparam int NTT_LMAX = NTT_AW;
    localparam int NTT_CNTW = $clog2(NTT_DW);

    localparam logic [NTT_DW-1:0] MOD_RESET = NTT_DW'(998244353);
    localparam logic [NTT_DW-1:0] GEN_RESET = NTT_DW'(3);
    localparam logic [NTT_KW-1:0] LOG_RESET = NTT_KW'(10);

    localparam logic [1:0] CFG_MODULUS   = 2'd0;
    localparam logic [1:0] CFG_GENERATOR = 2'd1;
    localparam logic [1:0] CFG_LOG_SIZE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_INV   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // multiplier operand A (must be below p)
    typedef enum logic [2:0] {
        A_ONE, A_ACC, A_SQ, A_CUR, A_NINV
    } t_asel;

    // multiplier operand B (any 31-bit value)
    typedef enum logic [2:0] {
        B_ONE, B_VALUE, B_Q, B_GEN, B_W, B_NVAL, B_SQ, B_ACC
    } t_bsel;

    typedef enum logic [2:0] {
        D_PROD, D_ACC, D_SQ, D_CUR, D_W, D_NINV
    } t_dst;

    typedef enum logic [2:0] {
        W_PROD, W_Q, W_U, W_SUM, W_DIFF
    } t_wsel;

    typedef struct packed {
        logic              mul_go;
        t_asel             a_sel;
        t_bsel             b_sel;
        t_dst              dst;
        logic              rd_en;
        logic [NTT_AW-1:0] rd_addr;
        logic              wr_en;
        logic [NTT_AW-1:0] wr_addr;
        t_wsel             w_sel;
        logic              cap_u;
        logic              exp_ld_stage;
        logic              exp_ld_inv;
        logic              exp_shift;
        logic [NTT_KW-1:0] stage;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
    } t_dp_stat;

    // reverse the low k bits of x
    function automatic logic [NTT_AW-1:0] bit_rev(input logic [NTT_AW-1:0] x,
                                                  input logic [NTT_KW-1:0] k);
        logic [NTT_AW-1:0] t;
        for (int b = 0; b < NTT_AW; b++) begin
            t[b] = x[NTT_AW-1-b];
        end
        return t >> (NTT_KW'(NTT_AW) - k);
    endfunction

endpackage

// ----- rtl/core/ntt_ram.sv -----
module ntt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ntt_modmul.sv -----
module ntt_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [ntt_pkg::NTT_DW-1:0] i_a,
    input  logic [ntt_pkg::NTT_DW-1:0] i_b,
    input  logic [ntt_pkg::NTT_DW-1:0] i_p,
    output logic                      o_done,
    output logic [ntt_pkg::NTT_DW-1:0] o_res
);
    import ntt_pkg::*;

    // interleaved shift-add: acc = (2*acc + bit*a) mod p, MSB of b first
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [NTT_CNTW-1:0] r_cnt, n_cnt;
    logic [NTT_DW-1:0]   r_acc, n_acc;
    logic [NTT_DW-1:0]   r_a, n_a;
    logic [NTT_DW-1:0]   r_b, n_b;
    logic [NTT_DW+1:0]   t_sum;
    logic [NTT_DW+1:0]   p1;
    logic [NTT_DW+1:0]   p2;

    always_comb begin
        p1    = (NTT_DW+2)'(i_p);
        p2    = p1 << 1;
        t_sum = ((NTT_DW+2)'(r_acc) << 1) + (r_b[NTT_DW-1] ? (NTT_DW+2)'(r_a) : '0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = NTT_CNTW'(NTT_DW-1);
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            if (t_sum >= p2) begin
                n_acc = NTT_DW'(t_sum - p2);
            end else if (t_sum >= p1) begin
                n_acc = NTT_DW'(t_sum - p1);
            end else begin
                n_acc = NTT_DW'(t_sum);
            end
            n_b = r_b << 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ----- rtl/core/ntt_dp.sv -----
module ntt_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ntt_pkg::t_dp_cmd           i_cmd,
    input  logic [ntt_pkg::NTT_DW-1:0] i_value,
    input  logic [ntt_pkg::NTT_DW-1:0] i_p,
    input  logic [ntt_pkg::NTT_DW-1:0] i_gen,
    input  logic [ntt_pkg::NTT_KW-1:0] i_log,
    output ntt_pkg::t_dp_stat          o_stat,
    output logic [ntt_pkg::NTT_DW-1:0] o_rdata
);
    import ntt_pkg::*;

    t_dst              r_dst;
    logic [NTT_DW-1:0] r_u, r_prod, r_acc, r_sq, r_cur, r_w, r_ninv, r_exp;
    logic [NTT_DW-1:0] q;
    logic [NTT_DW-1:0] mm_a, mm_b, mm_res;
    logic              mm_done;
    logic [NTT_DW-1:0] nval;
    logic [NTT_DW:0]   sum, diff;
    logic [NTT_DW-1:0] sum_red, diff_red, wdata;

    assign nval = NTT_DW'(1) << i_log;

    always_comb begin
        unique case (i_cmd.a_sel)
            A_ONE:   mm_a = NTT_DW'(1);
            A_ACC:   mm_a = r_acc;
            A_SQ:    mm_a = r_sq;
            A_CUR:   mm_a = r_cur;
            A_NINV:  mm_a = r_ninv;
            default: mm_a = NTT_DW'(1);
        endcase
        unique case (i_cmd.b_sel)
            B_ONE:   mm_b = NTT_DW'(1);
            B_VALUE: mm_b = i_value;
            B_Q:     mm_b = q;
            B_GEN:   mm_b = i_gen;
            B_W:     mm_b = r_w;
            B_NVAL:  mm_b = nval;
            B_SQ:    mm_b = r_sq;
            B_ACC:   mm_b = r_acc;
        endcase
    end

    ntt_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_p     (i_p),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

    // butterfly: u +/- v mod p, both inputs already below p
    always_comb begin
        sum      = (NTT_DW+1)'(r_u) + (NTT_DW+1)'(r_prod);
        diff     = (NTT_DW+1)'(r_u) + (NTT_DW+1)'(i_p) - (NTT_DW+1)'(r_prod);
        sum_red  = (sum >= (NTT_DW+1)'(i_p)) ? NTT_DW'(sum - (NTT_DW+1)'(i_p))
                                               : NTT_DW'(sum);
        diff_red = (diff >= (NTT_DW+1)'(i_p)) ? NTT_DW'(diff - (NTT_DW+1)'(i_p))
                                                : NTT_DW'(diff);
        unique case (i_cmd.w_sel)
            W_PROD:  wdata = r_prod;
            W_Q:     wdata = q;
            W_U:     wdata = r_u;
            W_SUM:   wdata = sum_red;
            W_DIFF:  wdata = diff_red;
            default: wdata = r_prod;
        endcase
    end

    ntt_ram #(.WIDTH(NTT_DW), .DEPTH(NTT_PTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_dst <= i_cmd.dst;
        end
        if (i_cmd.cap_u) begin
            r_u <= q;
        end
        if (mm_done) begin
            unique case (r_dst)
                D_PROD:  r_prod <= mm_res;
                D_ACC:   r_acc  <= mm_res;
                D_SQ:    r_sq   <= mm_res;
                D_CUR:   r_cur  <= mm_res;
                D_W:     r_w    <= mm_res;
                D_NINV:  r_ninv <= mm_res;
                default: r_prod <= mm_res;
            endcase
        end
        priority if (i_cmd.exp_ld_stage) begin
            r_exp <= (i_p - NTT_DW'(1)) >> i_cmd.stage;
        end else if (i_cmd.exp_ld_inv) begin
            r_exp <= i_p - NTT_DW'(2);
        end else if (i_cmd.exp_shift) begin
            r_exp <= r_exp >> 1;
        end
    end

    assign o_stat.mul_done = mm_done;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_rdata         = q;

endmodule

// ----- rtl/core/ntt_ctrl.sv -----
module ntt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_command,
    input  logic [ntt_pkg::NTT_AW-1:0] i_index,
    input  logic [ntt_pkg::NTT_KW-1:0] i_log,
    input  ntt_pkg::t_dp_stat          i_stat,
    output ntt_pkg::t_dp_cmd           o_cmd,
    output logic                       o_busy,
    output logic                       o_res_go,
    output logic                       o_res_done
);
    import ntt_pkg::*;

    typedef enum logic [30:0] {
        S_IDLE    = 31'd1 << 0,
        S_RD      = 31'd1 << 1,
        S_WR_ST   = 31'd1 << 2,
        S_MWAIT   = 31'd1 << 3,
        S_RED_RD  = 31'd1 << 4,
        S_RED_MUL = 31'd1 << 5,
        S_RED_WR  = 31'd1 << 6,
        S_REV_CHK = 31'd1 << 7,
        S_REV_RD2 = 31'd1 << 8,
        S_REV_W1  = 31'd1 << 9,
        S_REV_W2  = 31'd1 << 10,
        S_ST_INIT = 31'd1 << 11,
        S_ACC1    = 31'd1 << 12,
        S_PW_CHK  = 31'd1 << 13,
        S_PW_SQ   = 31'd1 << 14,
        S_ST_W    = 31'd1 << 15,
        S_ST_INV  = 31'd1 << 16,
        S_ST_W2   = 31'd1 << 17,
        S_GRP     = 31'd1 << 18,
        S_BF_RD1  = 31'd1 << 19,
        S_BF_RD2  = 31'd1 << 20,
        S_BF_MUL  = 31'd1 << 21,
        S_BF_W1   = 31'd1 << 22,
        S_BF_W2   = 31'd1 << 23,
        S_BF_NEXT = 31'd1 << 24,
        S_NI_INIT = 31'd1 << 25,
        S_NI_W    = 31'd1 << 26,
        S_SC_RD   = 31'd1 << 27,
        S_SC_MUL  = 31'd1 << 28,
        S_SC_WR   = 31'd1 << 29,
        S_FIN     = 31'd1 << 30
    } t_state;

    t_state            r_state, n_state;
    t_state            r_ret, n_ret;     // after a multiply
    t_state            r_pret, n_pret;   // after a power
    logic              r_inv, n_inv;
    logic [NTT_AW-1:0] r_i, n_i;
    logic [NTT_AW-1:0] r_base, n_base;
    logic [NTT_AW-1:0] r_j, n_j;
    logic [NTT_AW-1:0] r_addr, n_addr;
    logic [NTT_KW-1:0] r_s, n_s;

    logic [NTT_AW:0]   full_n, half, len;
    logic [NTT_AW-1:0] last_idx, addr1, addr2, rev;
    logic              grp_last;
    t_cmd              cmd_in;

    always_comb begin
        cmd_in   = t_cmd'(i_command);
        full_n   = (NTT_AW+1)'(1) << i_log;
        last_idx = NTT_AW'(full_n - 1'b1);
        half     = (NTT_AW+1)'(1) << (r_s - NTT_KW'(1));
        len      = half << 1;
        addr1    = r_base + r_j;
        addr2    = NTT_AW'((NTT_AW+1)'(addr1) + half);
        grp_last = (((NTT_AW+1)'(r_base) + len) == full_n);
        rev      = bit_rev(r_i, i_log);
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pret  = r_pret;
        n_inv   = r_inv;
        n_i     = r_i;
        n_base  = r_base;
        n_j     = r_j;
        n_addr  = r_addr;
        n_s     = r_s;
        o_cmd   = '0;
        o_cmd.stage = r_s;
        o_res_go   = 1'b0;
        o_res_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (cmd_in)
                        CMD_WRITE: begin
                            n_addr       = i_index;
                            o_cmd.mul_go = 1'b1;
                            o_cmd.b_sel  = B_VALUE;
                            n_ret        = S_WR_ST;
                            n_state      = S_MWAIT;
                        end
                        CMD_READ: begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = i_index;
                            n_state       = S_RD;
                        end
                        CMD_FWD, CMD_INV: begin
                            n_inv   = (cmd_in == CMD_INV);
                            n_i     = '0;
                            n_state = S_RED_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_res_go = 1'b1;
                n_state  = S_IDLE;
            end
            S_WR_ST: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_addr;
                o_cmd.w_sel   = W_PROD;
                n_state       = S_IDLE;
            end
            S_MWAIT: begin
                if (i_stat.mul_done) begin
                    n_state = r_ret;
                end
            end
            // reduce stale entries below p
            S_RED_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state       = S_RED_MUL;
            end
            S_RED_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.b_sel  = B_Q;
                n_ret        = S_RED_WR;
                n_state      = S_MWAIT;
            end
            S_RED_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.w_sel   = W_PROD;
                if (r_i == last_idx) begin
                    n_i     = '0;
                    n_state = S_REV_CHK;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RED_RD;
                end
            end
            // bit-reverse permutation
            S_REV_CHK: begin
                if (r_i < rev) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_i;
                    n_addr        = rev;
                    n_state       = S_REV_RD2;
                end else if (r_i == last_idx) begin
                    n_s     = NTT_KW'(1);
                    n_base  = '0;
                    n_j     = '0;
                    n_state = S_ST_INIT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_REV_RD2: begin
                o_cmd.cap_u   = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_addr;
                n_state       = S_REV_W1;
            end
            S_REV_W1: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.w_sel   = W_Q;
                n_state       = S_REV_W2;
            end
            S_REV_W2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_addr;
                o_cmd.w_sel   = W_U;
                n_i           = r_i + 1'b1;
                n_state       = S_REV_CHK;
            end
            // stage twiddle: w = g^((p-1)/len)
            S_ST_INIT: begin
                o_cmd.exp_ld_stage = 1'b1;
                o_cmd.mul_go       = 1'b1;
                o_cmd.b_sel        = B_GEN;
                o_cmd.dst          = D_SQ;
                n_ret              = S_ACC1;
                n_pret             = S_ST_W;
                n_state            = S_MWAIT;
            end
            S_ACC1: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.dst    = D_ACC;
                n_ret        = S_PW_CHK;
                n_state      = S_MWAIT;
            end
            S_PW_CHK: begin
                if (i_stat.exp_zero) begin
                    n_state = r_pret;
                end else if (i_stat.exp_lsb) begin
                    o_cmd.mul_go = 1'b1;
                    o_cmd.a_sel  = A_ACC;
                    o_cmd.b_sel  = B_SQ;
                    o_cmd.dst    = D_ACC;
                    n_ret        = S_PW_SQ;
                    n_state      = S_MWAIT;
                end else begin
                    n_state = S_PW_SQ;
                end
            end
            S_PW_SQ: begin
                o_cmd.mul_go    = 1'b1;
                o_cmd.a_sel     = A_SQ;
                o_cmd.b_sel     = B_SQ;
                o_cmd.dst       = D_SQ;
                o_cmd.exp_shift = 1'b1;
                n_ret           = S_PW_CHK;
                n_state         = S_MWAIT;
            end
            S_ST_W: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.b_sel  = B_ACC;
                o_cmd.dst    = D_W;
                n_ret        = r_inv ? S_ST_INV : S_GRP;
                n_state      = S_MWAIT;
            end
            S_ST_INV: begin
                o_cmd.exp_ld_inv = 1'b1;
                o_cmd.mul_go     = 1'b1;
                o_cmd.b_sel      = B_W;
                o_cmd.dst        = D_SQ;
                n_ret            = S_ACC1;
                n_pret           = S_ST_W2;
                n_state          = S_MWAIT;
            end
            S_ST_W2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.b_sel  = B_ACC;
                o_cmd.dst    = D_W;
                n_ret        = S_GRP;
                n_state      = S_MWAIT;
            end
            // butterflies
            S_GRP: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.dst    = D_CUR;
                n_j          = '0;
                n_ret        = S_BF_RD1;
                n_state      = S_MWAIT;
            end
            S_BF_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = addr1;
                n_state       = S_BF_RD2;
            end
            S_BF_RD2: begin
                o_cmd.cap_u   = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = addr2;
                n_state       = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.a_sel  = A_CUR;
                o_cmd.b_sel  = B_Q;
                n_ret        = S_BF_W1;
                n_state      = S_MWAIT;
            end
            S_BF_W1: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr1;
                o_cmd.w_sel   = W_SUM;
                n_state       = S_BF_W2;
            end
            S_BF_W2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = addr2;
                o_cmd.w_sel   = W_DIFF;
                o_cmd.mul_go  = 1'b1;
                o_cmd.a_sel   = A_CUR;
                o_cmd.b_sel   = B_W;
                o_cmd.dst     = D_CUR;
                n_ret         = S_BF_NEXT;
                n_state       = S_MWAIT;
            end
            S_BF_NEXT: begin
                if ((NTT_AW+1)'(r_j) == half - 1'b1) begin
                    n_j = '0;
                    if (grp_last) begin
                        n_base = '0;
                        if (r_s == i_log) begin
                            n_state = r_inv ? S_NI_INIT : S_FIN;
                        end else begin
                            n_s     = r_s + 1'b1;
                            n_state = S_ST_INIT;
                        end
                    end else begin
                        n_base  = NTT_AW'((NTT_AW+1)'(r_base) + len);
                        n_state = S_GRP;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_BF_RD1;
                end
            end
            // inverse scaling by n^-1
            S_NI_INIT: begin
                o_cmd.exp_ld_inv = 1'b1;
                o_cmd.mul_go     = 1'b1;
                o_cmd.b_sel      = B_NVAL;
                o_cmd.dst        = D_SQ;
                n_ret            = S_ACC1;
                n_pret           = S_NI_W;
                n_state          = S_MWAIT;
            end
            S_NI_W: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.b_sel  = B_ACC;
                o_cmd.dst    = D_NINV;
                n_i          = '0;
                n_ret        = S_SC_RD;
                n_state      = S_MWAIT;
            end
            S_SC_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state       = S_SC_MUL;
            end
            S_SC_MUL: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.a_sel  = A_NINV;
                o_cmd.b_sel  = B_Q;
                n_ret        = S_SC_WR;
                n_state      = S_MWAIT;
            end
            S_SC_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.w_sel   = W_PROD;
                if (r_i == last_idx) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_FIN: begin
                o_res_go   = 1'b1;
                o_res_done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pret  <= S_IDLE;
            r_inv   <= 1'b0;
            r_i     <= '0;
            r_base  <= '0;
            r_j     <= '0;
            r_s     <= NTT_KW'(1);
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pret  <= n_pret;
            r_inv   <= n_inv;
            r_i     <= n_i;
            r_base  <= n_base;
            r_j     <= n_j;
            r_s     <= n_s;
        end
        r_addr <= n_addr;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/core/number_theoretic_transform_core.sv -----
// Radix-2 number theoretic transform over a programmable prime p, working in
// place on a 1024-word coefficient RAM. Commands: write (word stored as value
// mod p), forward run, inverse run, read. start is taken when busy is low; a
// read or run answers with one o_strobe cycle that the receiver must catch,
// since it cannot hold results off; a write gives no answer. Every modular
// multiply goes through one bit-serial unit. A forward run of n = 2^log_size
// points first reduces every word mod p, then permutes them in bit-reversed
// order, and then, per stage, raises the generator to the twiddle power with
// up to 64 multiplies and does two multiplies per butterfly pair, with one
// more multiply per group. An inverse run about doubles the power work per
// stage and adds one more power plus a pass that scales every word by 1/n.
// The user must write configuration only while busy is low; the block itself
// does not enforce this. Every word in use must be written before a run.
module number_theoretic_transform_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic [ntt_pkg::NTT_AW-1:0] i_index,
    input  logic [ntt_pkg::NTT_DW-1:0] i_value,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [ntt_pkg::NTT_DW-1:0] i_cfg_data,
    output logic                       o_strobe,
    output logic [ntt_pkg::NTT_DW-1:0] o_value_res,
    output logic                       o_done_res
);
    import ntt_pkg::*;

    // config registers
    logic [NTT_DW-1:0] r_modulus;
    logic [NTT_DW-1:0] r_generator;
    logic [NTT_KW-1:0] r_log_size;

    // effective values: p at least 3, log size clamped to [1, LMAX]
    logic [NTT_DW-1:0] eff_p;
    logic [NTT_KW-1:0] eff_log;

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [NTT_DW-1:0] rdata;
    logic              res_go, res_done;

    logic              r_strobe;
    logic [NTT_DW-1:0] r_value;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MOD_RESET;
            r_generator <= GEN_RESET;
            r_log_size  <= LOG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODULUS:   r_modulus   <= i_cfg_data;
                CFG_GENERATOR: r_generator <= i_cfg_data;
                CFG_LOG_SIZE:  r_log_size  <= i_cfg_data[NTT_KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_p = (r_modulus < NTT_DW'(3)) ? NTT_DW'(3) : r_modulus;
        priority if (r_log_size == '0) begin
            eff_log = NTT_KW'(1);
        end else if (r_log_size > NTT_KW'(NTT_LMAX)) begin
            eff_log = NTT_KW'(NTT_LMAX);
        end else begin
            eff_log = r_log_size;
        end
    end

    ntt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_command  (i_command),
        .i_index    (i_index),
        .i_log      (eff_log),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (busy),
        .o_res_go   (res_go),
        .o_res_done (res_done)
    );

    ntt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_value (i_value),
        .i_p     (eff_p),
        .i_gen   (r_generator),
        .i_log   (eff_log),
        .o_stat  (dp_stat),
        .o_rdata (rdata)
    );

    // result register: read word, or zero with done for a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_go;
        end
        r_value <= res_done ? '0 : rdata;
        r_done  <= res_done;
    end

    assign o_strobe    = r_strobe;
    assign o_value_res = r_value;
    assign o_done_res  = r_done;

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // the cycle after any accept never carries a result
    a_no_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result strobe right after accept");

    // a read answers through the S_RD state and the result register, with done low
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_READ) |=> ##1 (o_strobe && !o_done_res))
        else $error("read word not delivered on time");

endmodule

// ----- verif/number_theoretic_transform_core_tb.sv -----
`timescale 1ns / 1ps

module number_theoretic_transform_core_tb;
    import ntt_pkg::*;

    // ---------------------------------------------------------------------
    // DUT hookup
    // ---------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [NTT_AW-1:0] i_index;
    logic [NTT_DW-1:0] i_value;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [NTT_DW-1:0] i_cfg_data;
    logic              o_strobe;
    logic [NTT_DW-1:0] o_value_res;
    logic              o_done_res;

    number_theoretic_transform_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_done_res  (o_done_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal test (a few dozen runs of up
    // to 32 points plus ~900 single words)
    initial begin
        #50_000_000;
        $display("number_theoretic_transform_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Shadow of the block: config, coefficient RAM, which words were loaded
    // ---------------------------------------------------------------------
    typedef struct {
        logic [NTT_DW-1:0] value;
        logic              done;
    } t_answer;

    t_answer           pending_answers[$];
    logic [NTT_DW-1:0] coef_mem[NTT_PTS];
    bit                loaded[NTT_PTS];
    logic [NTT_DW-1:0] sh_modulus;
    logic [NTT_DW-1:0] sh_generator;
    logic [NTT_KW-1:0] sh_log_size;
    int                fail_count;
    bit                idle_on;

    // modulus below 3 behaves as 3
    function automatic logic [NTT_DW-1:0] field_prime();
        return (sh_modulus < 3) ? NTT_DW'(3) : sh_modulus;
    endfunction

    // log_size saturates to [1, 10]
    function automatic int active_log();
        if (sh_log_size < 1) return 1;
        return (sh_log_size > NTT_LMAX) ? NTT_LMAX : int'(sh_log_size);
    endfunction

    function automatic logic [NTT_DW-1:0] mod_mul(logic [NTT_DW-1:0] a,
                                                  logic [NTT_DW-1:0] b,
                                                  logic [NTT_DW-1:0] p);
        logic [63:0] x;
        x = 64'(a) * 64'(b);
        return NTT_DW'(x % 64'(p));
    endfunction

    function automatic logic [NTT_DW-1:0] mod_pow(logic [NTT_DW-1:0] base,
                                                  logic [63:0] e,
                                                  logic [NTT_DW-1:0] p);
        logic [NTT_DW-1:0] acc;
        logic [NTT_DW-1:0] sq;
        acc = NTT_DW'(64'd1 % 64'(p));
        sq  = base % p;
        while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, sq, p);
            sq = mod_mul(sq, sq, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // in-place transform of the first n words, as the block does it
    task automatic transform_mem(input bit inverse);
        logic [NTT_DW-1:0] p;
        logic [NTT_DW-1:0] w;
        logic [NTT_DW-1:0] cur;
        logic [NTT_DW-1:0] u;
        logic [NTT_DW-1:0] v;
        logic [NTT_DW-1:0] t;
        logic [NTT_DW-1:0] ninv;
        int                k;
        int                n;
        int                r;
        p = field_prime();
        k = active_log();
        n = 1 << k;
        for (int i = 0; i < n; i++) coef_mem[i] = coef_mem[i] % p;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int b = 0; b < k; b++) r = (r << 1) | ((i >> b) & 1);
            if (i < r) begin
                t = coef_mem[i];
                coef_mem[i] = coef_mem[r];
                coef_mem[r] = t;
            end
        end
        for (int len = 2; len <= n; len = len << 1) begin
            w = mod_pow(sh_generator, 64'((p - 1) / NTT_DW'(len)), p);
            if (inverse) w = mod_pow(w, 64'(p - 2), p);
            for (int i = 0; i < n; i += len) begin
                cur = NTT_DW'(64'd1 % 64'(p));
                for (int j = 0; j < len / 2; j++) begin
                    u = coef_mem[i + j];
                    v = mod_mul(cur, coef_mem[i + j + len / 2], p);
                    coef_mem[i + j] = NTT_DW'((64'(u) + 64'(v)) % 64'(p));
                    coef_mem[i + j + len / 2] =
                        NTT_DW'((64'(u) + 64'(p) - 64'(v)) % 64'(p));
                    cur = mod_mul(cur, w, p);
                end
            end
        end
        if (inverse) begin
            ninv = mod_pow(NTT_DW'(64'(n) % 64'(p)), 64'(p - 2), p);
            for (int i = 0; i < n; i++) coef_mem[i] = mod_mul(coef_mem[i], ninv, p);
        end
    endtask

    // update the shadow for one accepted word and queue what it answers
    task automatic predict_word(input t_cmd cmd, input logic [NTT_AW-1:0] idx,
                                input logic [NTT_DW-1:0] val, input bit typed,
                                input logic [NTT_DW-1:0] typed_val);
        t_answer a;
        case (cmd)
            CMD_WRITE: begin
                coef_mem[idx] = val % field_prime();
                loaded[idx] = 1'b1;
            end
            CMD_READ: begin
                a.value = typed ? typed_val : coef_mem[idx];
                a.done  = 1'b0;
                pending_answers.push_back(a);
            end
            default: begin
                transform_mem(cmd == CMD_INV);
                a.value = '0;
                a.done  = 1'b1;
                pending_answers.push_back(a);
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Answer checker: every strobe must match the oldest queued answer
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected answer: value_res %0d done_res %0d",
                       o_value_res, o_done_res);
                fail_count++;
            end else begin
                if (o_value_res !== pending_answers[0].value) begin
                    $error("value_res: expected %0d, got %0d",
                           pending_answers[0].value, o_value_res);
                    fail_count++;
                end
                if (o_done_res !== pending_answers[0].done) begin
                    $error("done_res: expected %0d, got %0d",
                           pending_answers[0].done, o_done_res);
                    fail_count++;
                end
                void'(pending_answers.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driver. Tasks are entered and left at a falling edge.
    // ---------------------------------------------------------------------
    task automatic send_word(input t_cmd cmd, input logic [NTT_AW-1:0] idx,
                             input logic [NTT_DW-1:0] val, input bit typed,
                             input logic [NTT_DW-1:0] typed_val);
        // random sender gaps, ~26%
        while (idle_on && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_index   <= idx;
        i_value   <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_word(cmd, idx, val, typed, typed_val);
        @(negedge i_clk);
    endtask

    // drain: all answers in, block idle, then margin for a trailing write
    task automatic drain();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] sel, input logic [NTT_DW-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            CFG_MODULUS:   sh_modulus   = data;
            CFG_GENERATOR: sh_generator = data;
            CFG_LOG_SIZE:  sh_log_size  = data[NTT_KW-1:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Directed table: config rows and command rows; typed answers only
    // where they are obvious
    // ---------------------------------------------------------------------
    typedef enum logic { ROW_CMD, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_cmd              cmd;
        logic [1:0]        sel;
        logic [NTT_AW-1:0] idx;
        logic [NTT_DW-1:0] val;
        bit                typed;
        logic [NTT_DW-1:0] typed_val;
    } t_row;

    localparam int DIR_ROWS = 25;
    t_row dir_tab[DIR_ROWS] = '{
        // default field: extremes of index and value
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd1023, 31'h7FFFFFFF,   0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd1023, 31'd0,          1, 31'd150994941},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd0,    31'd0,          1, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd1,    31'd998244353,  0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd1,    31'd0,          1, 31'd0},
        // log_size 0 saturates up to a 2-point transform
        '{ROW_CFG, CMD_WRITE, CFG_LOG_SIZE, 10'd0,   31'd0,          0, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd0,    31'd1,          0, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd1,    31'd2,          0, 31'd0},
        '{ROW_CMD, CMD_FWD,   CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd0,    31'd0,          1, 31'd3},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd1,    31'd0,          1, 31'd998244352},
        '{ROW_CMD, CMD_INV,   CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0},
        // modulus 0 behaves as 3; old words are now stale
        '{ROW_CFG, CMD_WRITE, CFG_MODULUS,   10'd0,  31'd0,          0, 31'd0},
        '{ROW_CFG, CMD_WRITE, CFG_GENERATOR, 10'd0,  31'd2,          0, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd2,    31'h7FFFFFFF,   0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd2,    31'd0,          1, 31'd1},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd1023, 31'd0,          1, 31'd150994941},
        '{ROW_CMD, CMD_FWD,   CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0},
        '{ROW_CMD, CMD_READ,  CFG_MODULUS, 10'd1,    31'd0,          0, 31'd0},
        // largest modulus, largest generator
        '{ROW_CFG, CMD_WRITE, CFG_MODULUS,   10'd0,  31'h7FFFFFFF,   0, 31'd0},
        '{ROW_CFG, CMD_WRITE, CFG_GENERATOR, 10'd0,  31'h7FFFFFFE,   0, 31'd0},
        '{ROW_CMD, CMD_WRITE, CFG_MODULUS, 10'd3,    31'h7FFFFFFF,   0, 31'd0},
        '{ROW_CMD, CMD_INV,   CFG_MODULUS, 10'd0,    31'd0,          0, 31'd0}
    };

    // known-good (prime, primitive root) pairs for random phases
    localparam int NPAIRS = 6;
    logic [NTT_DW-1:0] prime_tab[NPAIRS] =
        '{31'd998244353, 31'd7681, 31'd12289, 31'd17, 31'd65537, 31'h7FFFFFFF};
    logic [NTT_DW-1:0] root_tab[NPAIRS] =
        '{31'd3, 31'd17, 31'd11, 31'd3, 31'd3, 31'd7};

    // load every word of the active transform that was never written
    task automatic fill_active();
        for (int i = 0; i < (1 << active_log()); i++)
            if (!loaded[i]) send_word(CMD_WRITE, NTT_AW'(i), NTT_DW'($urandom), 0, '0);
    endtask

    initial begin
        int                n;
        int                roll;
        int                pick;
        logic [NTT_AW-1:0] idx;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = CMD_WRITE;
        i_index     = '0;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MODULUS;
        i_cfg_data  = '0;
        fail_count  = 0;
        idle_on     = 1'b1;
        sh_modulus   = MOD_RESET;
        sh_generator = GEN_RESET;
        sh_log_size  = LOG_RESET;
        for (int i = 0; i < NTT_PTS; i++) begin
            coef_mem[i] = '0;
            loaded[i]   = 1'b0;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG)
                set_reg(dir_tab[r].sel, dir_tab[r].val);
            else
                send_word(dir_tab[r].cmd, dir_tab[r].idx, dir_tab[r].val,
                          dir_tab[r].typed, dir_tab[r].typed_val);
        end
        send_word(CMD_READ, 10'd0, '0, 0, '0);
        send_word(CMD_READ, 10'd3, '0, 0, '0);

        // random phases; small transforms keep runs short
        for (int ph = 0; ph < 8; ph++) begin
            pick = $urandom_range(NPAIRS - 1);
            if ($urandom_range(3) == 0) begin
                set_reg(CFG_MODULUS, NTT_DW'($urandom));
                set_reg(CFG_GENERATOR, NTT_DW'($urandom));
            end else begin
                set_reg(CFG_MODULUS, prime_tab[pick]);
                set_reg(CFG_GENERATOR, root_tab[pick]);
            end
            set_reg(CFG_LOG_SIZE, NTT_DW'($urandom_range(5)));
            idle_on = (ph != 2);     // one phase runs back to back
            fill_active();
            n = 1 << active_log();
            for (int it = 0; it < 100; it++) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    send_word($urandom_range(1) ? CMD_FWD : CMD_INV, '0, '0, 0, '0);
                end else if (roll < 45) begin
                    idx = ($urandom_range(3) != 0) ? NTT_AW'($urandom_range(n - 1))
                                                   : NTT_AW'($urandom);
                    if (loaded[idx]) send_word(CMD_READ, idx, '0, 0, '0);
                    else send_word(CMD_WRITE, idx, NTT_DW'($urandom), 0, '0);
                end else begin
                    idx = ($urandom_range(9) < 7) ? NTT_AW'($urandom_range(n - 1))
                                                  : NTT_AW'($urandom);
                    send_word(CMD_WRITE, idx, NTT_DW'($urandom), 0, '0);
                end
            end
            idle_on = 1'b1;
        end

        drain();
        if (fail_count == 0)
            $display("number_theoretic_transform_core: match");
        else
            $display("number_theoretic_transform_core: mismatch");
        $finish;
    end

endmodule
